[rtl/smds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix store package
// Shared widths, codes and item types of the sparse matrix store.
// ----------------------------------------------------------------------------
package smds_pkg;

    // Default number of hash slots.
    localparam int unsigned DEF_CAPACITY = 256;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned KEY_W   = 2 * COORD_W;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 9;

    // Action codes carried by an input item.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // One input item.
    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
        logic signed [DATA_W-1:0]  value;
    } smds_in_t;

    // One result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [COUNT_W-1:0]       entry_count;
        logic                     dropped;
    } smds_out_t;

endpackage

[rtl/smds_home.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces the 16-bit row/column hash modulo the slot count. A power-of-two
// slot count registers the low bits; any other count registers the quotient
// from the rounded-up reciprocal, then subtracts the product back.
// ----------------------------------------------------------------------------
module smds_home
    import smds_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COORD_W-1:0]          hash_in,
    output logic                        done,
    output logic [$clog2(CAPACITY)-1:0] home
);

    localparam int unsigned AW      = $clog2(CAPACITY);
    localparam bit          IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic          done_reg;
            logic [AW-1:0] home_reg;

            // The remainder is simply the low bits of the hash.
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    home_reg <= hash_in[AW-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_recip
            localparam int unsigned          SH      = COORD_W + AW;
            localparam logic [63:0]          RECIP64 =
                ((64'd1 << SH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
            localparam logic [2*COORD_W:0]   RECIP   = RECIP64[2*COORD_W:0];
            localparam logic [COORD_W-1:0]   CAP_W   = COORD_W'(CAPACITY);

            logic                 stage_reg;
            logic                 done_reg;
            logic [COORD_W-1:0]   hash_reg;
            logic [COORD_W-1:0]   quot_reg;
            logic [AW-1:0]        home_reg;
            logic [2*COORD_W:0]   prod;
            logic [COORD_W-1:0]   back;

            // Quotient from the rounded-up reciprocal; exact for every 16-bit hash.
            assign prod = (2*COORD_W+1)'(hash_in) * RECIP;
            // The remainder always fits in the slot index width.
            assign back = hash_reg - quot_reg * CAP_W;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end else begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
                if (start) begin
                    hash_reg <= hash_in;
                    quot_reg <= COORD_W'(prod >> SH);
                end
                if (stage_reg) begin
                    home_reg <= back[AW-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
    endgenerate

endmodule

[rtl/sparse_matrix_default_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix store, top level
// An accepted item goes through the home slot unit, a linear probe and the output
// register; the next item is taken once the result is loaded, later while m_ready
// stalls. A slot count that is not a power of two uses the reciprocal path for
// the home slot. The probe reads one slot per cycle from the slot memory's single
// read port. After reset a clearing pass empties every slot before the first item.
// ----------------------------------------------------------------------------
module sparse_matrix_default_store_top
    import smds_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  smds_in_t                 s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output smds_out_t                m_item,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [DATA_W-1:0] cfg_data
);

    localparam int unsigned AW     = $clog2(CAPACITY);
    localparam int unsigned CW     = $clog2(CAPACITY + 1);
    localparam int unsigned WORD_W = 1 + KEY_W + DATA_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HOME  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [AW-1:0]            clr_idx_reg, clr_idx_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            step_reg, step_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0] dflt_reg, dflt_next;
    smds_in_t                 item_reg, item_next;
    smds_out_t                res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    smds_out_t                m_item_reg, m_item_next;

    // Slot memory: {valid, key, data} per slot.
    logic [WORD_W-1:0] slot_mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic                  accept;
    logic                  home_done;
    logic [AW-1:0]         home;
    logic [AW-1:0]         idx_inc;
    logic                  slot_valid;
    logic [KEY_W-1:0]      slot_key;
    logic [DATA_W-1:0]     slot_data;
    logic [KEY_W-1:0]      item_key;
    logic                  hit;
    logic                  exhausted;
    logic [CW-1:0]         cnt_after;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Home slot of the incoming item.
    smds_home #(
        .CAPACITY (CAPACITY)
    ) u_home (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hash_in (s_item.row ^ s_item.col),
        .done    (home_done),
        .home    (home)
    );

    // Fields of the slot read in the previous cycle.
    assign slot_valid = rd_data_reg[WORD_W-1];
    assign slot_key   = rd_data_reg[DATA_W +: KEY_W];
    assign slot_data  = rd_data_reg[DATA_W-1:0];
    assign item_key   = {item_reg.row, item_reg.col};
    assign hit        = slot_valid && (slot_key == item_key);
    assign exhausted  = (step_reg == LAST_IDX);
    assign idx_inc    = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Sequencer: clearing pass, home slot, linear probe, result hand-off.
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        dflt_next    = dflt_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_inc;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = {1'b1, item_key, item_reg.value};
        cnt_after    = count_reg;
        cnt_ext      = '0;

        if (cfg_valid && cfg_ready) begin
            dflt_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_item;
                    state_next = ST_HOME;
                end
            end
            ST_HOME: begin
                // Issue the read of the home slot as soon as it is known.
                if (home_done) begin
                    rd_en      = 1'b1;
                    rd_addr    = home;
                    idx_next   = home;
                    step_next  = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // Read the following slot ahead while this one is compared.
                rd_en = 1'b1;
                if (hit || !slot_valid || exhausted) begin
                    res_next.found       = hit;
                    res_next.dropped     = 1'b0;
                    res_next.read_value  = '0;
                    if (item_reg.action == ACT_READ) begin
                        res_next.read_value = hit ? signed'(slot_data) : dflt_reg;
                    end else if (hit) begin
                        wr_en = 1'b1;
                    end else if (!slot_valid && (count_reg < CAP_CNT)) begin
                        wr_en     = 1'b1;
                        cnt_after = count_reg + 1'b1;
                    end else begin
                        res_next.dropped = 1'b1;
                    end
                    count_next           = cnt_after;
                    cnt_ext              = (CW + COUNT_W)'(cnt_after);
                    res_next.entry_count = cnt_ext[COUNT_W-1:0];
                    state_next           = ST_OUT;
                end else begin
                    idx_next  = idx_inc;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT: begin
                // Load the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            dflt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            dflt_reg    <= dflt_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    // Slot memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

endmodule

[rtl/smds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix store checker
// Port-level assertions on the sparse matrix store, bound to the top level.
// ----------------------------------------------------------------------------
module smds_checker
    import smds_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input smds_out_t                m_item
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // Reset starts the clearing pass: no item taken, no result shown.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("store not quiet after reset");

    // Only one item is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    // A refused write only happens for a new cell in a full table.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.dropped |-> !m_item.found && m_item.entry_count == FULL_COUNT)
        else $error("item dropped while table not full");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

endmodule

bind sparse_matrix_default_store_top smds_checker #(
    .CAPACITY (CAPACITY)
) u_smds_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix store testbench
// Drives reads and writes of matrix cells through the store, keeps its own
// copy of the hash table to predict every result, and checks each result
// field by field. Runs directed cell cases, default register changes, random
// mixed traffic, a fill to capacity and traffic on a full table.
// ----------------------------------------------------------------------------
module tb_top;
    import smds_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    // Worst quiet stretch: clearing pass, a full probe, a stall and a gap.
    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    smds_in_t                 s_item    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    smds_out_t                m_item;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic signed [DATA_W-1:0] cfg_data  = '0;

    // Predicted copy of the table and the default register.
    bit                       store_used [CAP];
    bit [KEY_W-1:0]           store_key  [CAP];
    logic signed [DATA_W-1:0] store_data [CAP];
    int                       store_count = 0;
    logic signed [DATA_W-1:0] default_reg = '0;

    smds_out_t expected_results[$];

    int error_count  = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int hit_count    = 0;
    int drop_count   = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int ready_run    = 0;
    int ready_hold   = 0;

    bit [KEY_W-1:0] key_pool[48];

    sparse_matrix_default_store_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result receiver: runs of readiness broken by stalls of random length.
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            m_ready   <= 1'b1;
            ready_run <= ready_run - 1;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_run  <= $urandom_range(1, 24);
            ready_hold <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Predicts one access to the table and updates the predicted state.
    function automatic smds_out_t predict_access(input smds_in_t it);
        smds_out_t      r;
        bit [KEY_W-1:0] key;
        bit [15:0]      mix;
        int             home;
        int             idx;
        int             where;
        bit             hit;
        bit             stop;
        key   = {it.row, it.col};
        mix   = it.row ^ it.col;
        home  = int'(mix) % CAP;
        where = CAP;
        hit   = 1'b0;
        stop  = 1'b0;
        // Linear probe with wrap-around, ending at an empty slot or the key.
        for (int i = 0; i < CAP; i++) begin
            if (!stop) begin
                idx = (home + i) % CAP;
                if (!store_used[idx]) begin
                    where = idx;
                    stop  = 1'b1;
                end else if (store_key[idx] == key) begin
                    where = idx;
                    hit   = 1'b1;
                    stop  = 1'b1;
                end
            end
        end
        r = '0;
        if (it.action == ACT_READ) begin
            r.read_value = hit ? store_data[where] : default_reg;
        end else if (hit) begin
            store_data[where] = it.value;
        end else if (where < CAP && store_count < CAP) begin
            store_used[where] = 1'b1;
            store_key[where]  = key;
            store_data[where] = it.value;
            store_count++;
        end else begin
            r.dropped = 1'b1;
            drop_count++;
        end
        if (hit) begin
            hit_count++;
        end
        r.found       = hit;
        r.entry_count = store_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic smds_in_t make_item(input logic act, input bit [KEY_W-1:0] key,
                                           input logic [DATA_W-1:0] val);
        smds_in_t it;
        it.action = act;
        it.row    = key[31:16];
        it.col    = key[15:0];
        it.value  = val;
        return it;
    endfunction

    // A random key: half spread over the whole plane, half crowded on a few homes.
    function automatic bit [KEY_W-1:0] fresh_key();
        bit [15:0] r;
        bit [15:0] c;
        r = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            c = $urandom;
        end else begin
            c = r ^ {8'($urandom), 8'($urandom_range(0, 15))};
        end
        return {r, c};
    endfunction

    // Sends one item in bursts with random gaps, then records its prediction.
    task automatic send_item(input smds_in_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_access(it));
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the default value register while the store is idle.
    task automatic write_default(input logic signed [DATA_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        default_reg = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Result checker: each result against the oldest prediction.
    always @(posedge aclk) begin : check_results
        smds_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected result: value %0d found %0b count %0d dropped %0b",
                             m_item.read_value, m_item.found, m_item.entry_count,
                             m_item.dropped);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_item.read_value !== want.read_value || m_item.found !== want.found ||
                    m_item.entry_count !== want.entry_count ||
                    m_item.dropped !== want.dropped) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d: expected value %0d found %0b",
                                 results_seen, want.read_value, want.found);
                        $display("  count %0d dropped %0b, got value %0d found %0b",
                                 want.entry_count, want.dropped, m_item.read_value,
                                 m_item.found);
                        $display("  count %0d dropped %0b", m_item.entry_count,
                                 m_item.dropped);
                    end
                end
            end
        end
    end

    // Extreme coordinates and values, overwrites, collisions and wrap-around.
    task automatic test_directed_cells();
        send_item(make_item(ACT_READ,  {16'h0000, 16'h0000}, 32'h1234_5678));
        send_item(make_item(ACT_WRITE, {16'h0000, 16'h0000}, 32'h7FFF_FFFF));
        send_item(make_item(ACT_READ,  {16'h0000, 16'h0000}, 32'h0));
        send_item(make_item(ACT_WRITE, {16'h0000, 16'h0000}, 32'h8000_0000));
        send_item(make_item(ACT_READ,  {16'h0000, 16'h0000}, 32'hFFFF_FFFF));
        // Three keys share the last home slot, so the chain wraps to the start.
        send_item(make_item(ACT_WRITE, {16'h8000, 16'h7FFF}, 32'hFFFF_FFFF));
        send_item(make_item(ACT_WRITE, {16'h7FFF, 16'h8000}, 32'h0000_0001));
        send_item(make_item(ACT_WRITE, {16'hFFFF, 16'h0000}, 32'hA5A5_A5A5));
        send_item(make_item(ACT_READ,  {16'h7FFF, 16'h8000}, 32'h0));
        send_item(make_item(ACT_READ,  {16'hFFFF, 16'h0000}, 32'h0));
        send_item(make_item(ACT_READ,  {16'h8000, 16'h7FFF}, 32'h0));
        // Absent cells whose probes run along the occupied chains.
        send_item(make_item(ACT_READ,  {16'hFFFF, 16'hFFFF}, 32'h0));
        send_item(make_item(ACT_READ,  {16'h0000, 16'hFFFF}, 32'h0));
        // Same home as the origin through equal row and column.
        send_item(make_item(ACT_WRITE, {16'h1234, 16'h1234}, 32'h5A5A_5A5A));
        send_item(make_item(ACT_READ,  {16'h1234, 16'h1234}, 32'h0));
        send_item(make_item(ACT_WRITE, {16'h0000, 16'h0000}, 32'h0));
        send_item(make_item(ACT_READ,  {16'h0000, 16'h0000}, 32'h0));
        send_item(make_item(ACT_READ,  {16'h0001, 16'h0000}, 32'h0));
        drain();
    endtask

    // The default value appears on misses only, at its extremes and between.
    task automatic test_default_register();
        write_default(32'sh8000_0000);
        send_item(make_item(ACT_READ, {16'h0005, 16'h0005}, 32'h0));
        write_default(32'sh7FFF_FFFF);
        send_item(make_item(ACT_READ, {16'hFFFE, 16'h0007}, 32'h0));
        send_item(make_item(ACT_READ, {16'h0000, 16'h0000}, 32'h0));
        write_default(32'sh55AA_33CC);
        send_item(make_item(ACT_READ, {16'h8000, 16'h8000}, 32'h0));
        drain();
    endtask

    // Random reads and writes, mostly on a small pool of keys so that hits occur.
    task automatic test_random_mixed(input int count);
        bit [KEY_W-1:0] key;
        logic           act;
        foreach (key_pool[i]) begin
            key_pool[i] = fresh_key();
        end
        for (int n = 0; n < count; n++) begin
            if (n % 125 == 0) begin
                write_default($urandom);
            end
            key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 47)] : fresh_key();
            act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            send_item(make_item(act, key, $urandom));
        end
        drain();
    endtask

    // New cells until every slot is taken, with reads in between.
    task automatic test_fill_table();
        write_default(32'sh0000_0000);
        while (store_count < CAP) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(make_item(ACT_READ, key_pool[$urandom_range(0, 47)], $urandom));
            end else begin
                send_item(make_item(ACT_WRITE, fresh_key(), $urandom));
            end
        end
        drain();
    endtask

    // Full table: overwrites still land, new cells are refused, misses probe all.
    task automatic test_full_table(input int count);
        bit [KEY_W-1:0] key;
        logic           act;
        for (int n = 0; n < count; n++) begin
            if (n == 0) begin
                write_default(32'sh7FFF_FFFF);
            end else if (n == count / 2) begin
                write_default(32'sh8000_0000);
            end
            case ($urandom_range(0, 3))
                0: begin
                    key = store_key[$urandom_range(0, CAP - 1)];
                    act = ACT_WRITE;
                end
                1: begin
                    key = fresh_key();
                    act = ACT_WRITE;
                end
                2: begin
                    key = store_key[$urandom_range(0, CAP - 1)];
                    act = ACT_READ;
                end
                default: begin
                    key = fresh_key();
                    act = ACT_READ;
                end
            endcase
            send_item(make_item(act, key, $urandom));
        end
        drain();
    endtask

    initial begin
        foreach (store_used[i]) begin
            store_used[i] = 1'b0;
            store_key[i]  = '0;
            store_data[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cells();
        test_default_register();
        test_random_mixed(550);
        test_fill_table();
        test_full_table(550);

        drain();
        repeat (300) @(posedge aclk);

        $display("Ran %0d items and %0d results over %0d default settings.",
                 items_sent, results_seen, cfg_writes + 1);
        $display("Saw %0d hits and %0d refused writes, ending with %0d cells held.",
                 hit_count, drop_count, store_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures found", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/smds_pkg.sv
rtl/smds_home.sv
rtl/sparse_matrix_default_store_top.sv
rtl/smds_checker.sv
sim/tb_top.sv
